// ===== src/jts_pkg.sv =====
// Package for the job table scheduler: field widths, codes, datapath
// command and status types, controller state type. No dependencies.
package jts_pkg;

  localparam int FIELD_W   = 16;
  localparam int CLOCK_W   = 21;
  localparam int LEFT_W    = 5;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 32;

  localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SJF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE = 2'd1;

  localparam logic REQ_PUSH     = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSH_OK    = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_REJECT, OP_EMPTY,
    OP_PUSH_RD, OP_PUSH_SHIFT, OP_PUSH_PUT,
    OP_HEAD_RD, OP_FCFS_GET,
    OP_SJF_FIRST, OP_SJF_RD, OP_SJF_CMP, OP_SJF_DONE,
    OP_RR_RD, OP_RR_GET,
    OP_DROP_RD, OP_DROP_WR, OP_DROP_DONE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic table_full;
    logic mode_sjf;
    logic mode_rr;
    logic idx_one;
    logic push_shift;
    logic scan_more;
    logic scan_hit;
    logic drop_more;
    logic rr_fits;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_REJECT, S_EMPTY,
    S_PUSH_RD, S_PUSH_CMP, S_PUSH_PUT,
    S_FCFS_RD, S_FCFS_GET,
    S_SJF_HEAD, S_SJF_FIRST, S_SJF_RD, S_SJF_CMP,
    S_RR_RD, S_RR_GET,
    S_DROP_RD, S_DROP_WR,
    S_EMIT
  } ctrl_state_t;

endpackage

// ===== src/jts_if.sv =====
// Channel interfaces of the job table scheduler: request, result and
// configuration write. Depends on jts_pkg.
interface jts_req_if;
  import jts_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [FIELD_W-1:0] arrival_time;
  logic [FIELD_W-1:0] burst_length;
  modport source (output valid, req_type, arrival_time, burst_length, input ready);
  modport sink (input valid, req_type, arrival_time, burst_length, output ready);
endinterface

interface jts_res_if;
  import jts_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FIELD_W-1:0] task_arrival;
  logic [FIELD_W-1:0] task_burst;
  logic               task_removed;
  logic [CLOCK_W-1:0] finish_time;
  logic [LEFT_W-1:0]  entries_left;
  modport source (output valid, status, task_arrival, task_burst, task_removed,
                  finish_time, entries_left, input ready);
  modport sink (input valid, status, task_arrival, task_burst, task_removed,
                finish_time, entries_left, output ready);
endinterface

interface jts_cfg_if;
  import jts_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/jts_ctrl.sv =====
// Controller of the job table scheduler: sequences push, dispatch and
// entry-move steps. Depends on jts_pkg.
module jts_ctrl
  import jts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  logic       req_type,
  output logic       req_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    req_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        // no word is taken while reset is held
        req_ready = rst_n;
        if (req_valid && rst_n) begin
          cmd.op = OP_LOAD;
          if (req_type == REQ_PUSH) begin
            if (sts.table_full)      state_nxt = S_REJECT;
            else if (sts.count_zero) state_nxt = S_PUSH_PUT;
            else                     state_nxt = S_PUSH_RD;
          end else begin
            if (sts.count_zero)    state_nxt = S_EMPTY;
            else if (sts.mode_sjf) state_nxt = S_SJF_HEAD;
            else if (sts.mode_rr)  state_nxt = S_RR_RD;
            else                   state_nxt = S_FCFS_RD;
          end
        end
      end
      S_REJECT: begin
        cmd.op    = OP_REJECT;
        state_nxt = S_EMIT;
      end
      S_EMPTY: begin
        cmd.op    = OP_EMPTY;
        state_nxt = S_EMIT;
      end
      S_PUSH_RD: begin
        cmd.op    = OP_PUSH_RD;
        state_nxt = S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        if (sts.push_shift) begin
          cmd.op    = OP_PUSH_SHIFT;
          state_nxt = sts.idx_one ? S_PUSH_PUT : S_PUSH_RD;
        end else begin
          state_nxt = S_PUSH_PUT;
        end
      end
      S_PUSH_PUT: begin
        cmd.op    = OP_PUSH_PUT;
        state_nxt = S_EMIT;
      end
      S_FCFS_RD: begin
        cmd.op    = OP_HEAD_RD;
        state_nxt = S_FCFS_GET;
      end
      S_FCFS_GET: begin
        cmd.op    = OP_FCFS_GET;
        state_nxt = S_DROP_RD;
      end
      S_SJF_HEAD: begin
        cmd.op    = OP_HEAD_RD;
        state_nxt = S_SJF_FIRST;
      end
      S_SJF_FIRST: begin
        cmd.op    = OP_SJF_FIRST;
        state_nxt = S_SJF_RD;
      end
      S_SJF_RD: begin
        if (sts.scan_more) begin
          cmd.op    = OP_SJF_RD;
          state_nxt = S_SJF_CMP;
        end else begin
          cmd.op    = OP_SJF_DONE;
          state_nxt = S_DROP_RD;
        end
      end
      S_SJF_CMP: begin
        if (sts.scan_hit) begin
          cmd.op    = OP_SJF_CMP;
          state_nxt = S_SJF_RD;
        end else begin
          cmd.op    = OP_SJF_DONE;
          state_nxt = S_DROP_RD;
        end
      end
      S_RR_RD: begin
        cmd.op    = OP_RR_RD;
        state_nxt = S_RR_GET;
      end
      S_RR_GET: begin
        cmd.op    = OP_RR_GET;
        state_nxt = sts.rr_fits ? S_DROP_RD : S_EMIT;
      end
      S_DROP_RD: begin
        if (sts.drop_more) begin
          cmd.op    = OP_DROP_RD;
          state_nxt = S_DROP_WR;
        end else begin
          cmd.op    = OP_DROP_DONE;
          state_nxt = S_EMIT;
        end
      end
      S_DROP_WR: begin
        cmd.op    = OP_DROP_WR;
        state_nxt = S_DROP_RD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/jts_datapath.sv =====
// Datapath of the job table scheduler: task table memory, counters,
// SJF clock, rotation position, config registers, result register.
// Depends on jts_pkg.
module jts_datapath
  import jts_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           sts,
  input  logic [FIELD_W-1:0]   req_arrival,
  input  logic [FIELD_W-1:0]   req_burst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  input  logic                 res_ready,
  output logic                 res_valid,
  output logic [1:0]           res_status,
  output logic [FIELD_W-1:0]   res_arrival,
  output logic [FIELD_W-1:0]   res_burst,
  output logic                 res_removed,
  output logic [CLOCK_W-1:0]   res_finish,
  output logic [LEFT_W-1:0]    res_left
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int KW = (VW > CLOCK_W) ? VW : CLOCK_W;
  localparam int MW = (VW > FIELD_W) ? VW : FIELD_W;

  // table memory, one write and one registered read per cycle
  logic [VW-1:0] arr_mem [TABLE_DEPTH];
  logic [VW-1:0] bst_mem [TABLE_DEPTH];
  logic [VW-1:0] rd_a_r, rd_b_r;

  logic [MODE_W-1:0]  mode_r;
  logic [FIELD_W-1:0] slice_r;
  logic [CW-1:0]      count_r;
  logic [KW-1:0]      clock_r;
  logic [AW-1:0]      rot_r;
  logic [CW-1:0]      idx_r;
  logic [AW-1:0]      best_r;
  logic [VW-1:0]      new_a_r, new_b_r, best_a_r, best_b_r;

  status_t            st_r;
  logic [VW-1:0]      r_arr_r, r_bst_r;
  logic               r_rem_r;
  logic [CLOCK_W-1:0] r_fin_r;

  logic               out_valid_r;
  status_t            out_st_r;
  logic [VW-1:0]      out_arr_r, out_bst_r;
  logic               out_rem_r;
  logic [CLOCK_W-1:0] out_fin_r;
  logic [CW-1:0]      out_left_r;

  logic [AW-1:0]      raddr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VW-1:0]      wdata_a, wdata_b;

  logic [CW-1:0]      rr_pos_w;
  logic [CW-1:0]      rr_next_w;
  logic [SUM_W-1:0]   sum_w;
  logic [CLOCK_W-1:0] sat_w;
  logic [CW:0]        idx_inc_w;
  logic [CW-1:0]      cnt_dec_w;
  logic [AW-1:0]      rot_dec_w;
  logic [CW-1:0]      idx_m1_w;
  logic [CW-1:0]      idx_p1_w;
  logic               out_free_w;

  assign rr_pos_w   = (CW'(rot_r) >= count_r) ? '0 : CW'(rot_r);
  assign rr_next_w  = CW'(best_r) + CW'(1);
  assign sum_w      = SUM_W'(clock_r) + SUM_W'(best_b_r);
  assign sat_w      = (sum_w > SUM_W'(CLOCK_MAX)) ? CLOCK_MAX : sum_w[CLOCK_W-1:0];
  assign idx_inc_w  = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_m1_w   = idx_r - CW'(1);
  assign idx_p1_w   = idx_r + CW'(1);
  assign cnt_dec_w  = count_r - CW'(1);
  assign rot_dec_w  = (best_r < rot_r) ? rot_r - AW'(1) : rot_r;
  assign out_free_w = !out_valid_r || res_ready;

  always_comb begin
    sts.count_zero = (count_r == '0);
    sts.table_full = (count_r >= CW'(TABLE_DEPTH));
    sts.mode_sjf   = (mode_r == MODE_SJF);
    sts.mode_rr    = (mode_r == MODE_RR);
    sts.idx_one    = (idx_r == CW'(1));
    // stored entry sorts at or after the new task: it moves up one slot
    sts.push_shift = (rd_a_r > new_a_r) || ((rd_a_r == new_a_r) && (rd_b_r >= new_b_r));
    sts.scan_more  = (idx_r < count_r);
    sts.scan_hit   = (KW'(rd_a_r) <= clock_r);
    sts.drop_more  = (idx_inc_w < {1'b0, count_r});
    sts.rr_fits    = (MW'(rd_b_r) <= MW'(slice_r));
    sts.out_free   = out_free_w;
  end

  always_comb begin
    raddr   = '0;
    we      = 1'b0;
    waddr   = idx_r[AW-1:0];
    wdata_a = rd_a_r;
    wdata_b = rd_b_r;
    case (cmd.op)
      OP_PUSH_RD:    raddr = idx_m1_w[AW-1:0];
      OP_PUSH_SHIFT: we = 1'b1;
      OP_PUSH_PUT: begin
        we      = 1'b1;
        wdata_a = new_a_r;
        wdata_b = new_b_r;
      end
      OP_SJF_RD:     raddr = idx_r[AW-1:0];
      OP_RR_RD:      raddr = rr_pos_w[AW-1:0];
      OP_RR_GET: begin
        we      = !sts.rr_fits;
        waddr   = best_r;
        wdata_b = VW'(MW'(rd_b_r) - MW'(slice_r));
      end
      OP_DROP_RD:    raddr = idx_p1_w[AW-1:0];
      OP_DROP_WR:    we = 1'b1;
      default:       raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      arr_mem[waddr] <= wdata_a;
      bst_mem[waddr] <= wdata_b;
    end
    rd_a_r <= arr_mem[raddr];
    rd_b_r <= bst_mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FCFS;
      slice_r     <= FIELD_W'(1);
      count_r     <= '0;
      clock_r     <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE)       mode_r  <= cfg_data[MODE_W-1:0];
        else if (cfg_index == REG_SLICE) slice_r <= cfg_data;
      end
      case (cmd.op)
        OP_PUSH_PUT: begin
          if (count_r != '0 && idx_r[AW-1:0] <= rot_r) rot_r <= rot_r + AW'(1);
          count_r <= count_r + CW'(1);
        end
        OP_SJF_FIRST: begin
          if (KW'(rd_a_r) > clock_r) clock_r <= KW'(rd_a_r);
        end
        OP_SJF_DONE: clock_r <= KW'(sat_w);
        OP_RR_RD:    rot_r <= rr_pos_w[AW-1:0];
        OP_RR_GET: begin
          if (!sts.rr_fits) rot_r <= (rr_next_w >= count_r) ? '0 : rr_next_w[AW-1:0];
        end
        OP_DROP_DONE: begin
          count_r <= cnt_dec_w;
          rot_r   <= (CW'(rot_dec_w) >= cnt_dec_w) ? '0 : rot_dec_w;
          if (cnt_dec_w == '0) clock_r <= '0;
        end
        default: count_r <= count_r;
      endcase
      if (cmd.op == OP_EMIT)  out_valid_r <= 1'b1;
      else if (res_ready)     out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        new_a_r <= VW'(req_arrival);
        new_b_r <= VW'(req_burst);
        idx_r   <= count_r;
      end
      OP_REJECT, OP_EMPTY, OP_PUSH_PUT: begin
        st_r    <= (cmd.op == OP_REJECT) ? ST_FULL :
                   (cmd.op == OP_EMPTY) ? ST_EMPTY : ST_PUSH_OK;
        r_arr_r <= '0;
        r_bst_r <= '0;
        r_rem_r <= 1'b0;
        r_fin_r <= '0;
      end
      OP_PUSH_SHIFT: idx_r <= idx_m1_w;
      OP_FCFS_GET: begin
        st_r    <= ST_DISPATCHED;
        r_arr_r <= rd_a_r;
        r_bst_r <= rd_b_r;
        r_rem_r <= 1'b1;
        r_fin_r <= '0;
        idx_r   <= '0;
        best_r  <= '0;
      end
      OP_SJF_FIRST: begin
        best_r   <= '0;
        best_a_r <= rd_a_r;
        best_b_r <= rd_b_r;
        idx_r    <= CW'(1);
      end
      OP_SJF_CMP: begin
        if (rd_b_r < best_b_r) begin
          best_r   <= idx_r[AW-1:0];
          best_a_r <= rd_a_r;
          best_b_r <= rd_b_r;
        end
        idx_r <= idx_p1_w;
      end
      OP_SJF_DONE: begin
        st_r    <= ST_DISPATCHED;
        r_arr_r <= best_a_r;
        r_bst_r <= best_b_r;
        r_rem_r <= 1'b1;
        r_fin_r <= sat_w;
        idx_r   <= CW'(best_r);
      end
      OP_RR_RD: begin
        idx_r  <= rr_pos_w;
        best_r <= rr_pos_w[AW-1:0];
      end
      OP_RR_GET: begin
        st_r    <= ST_DISPATCHED;
        r_arr_r <= rd_a_r;
        r_bst_r <= rd_b_r;
        r_rem_r <= sts.rr_fits;
        r_fin_r <= '0;
      end
      OP_DROP_WR: idx_r <= idx_p1_w;
      OP_EMIT: begin
        out_st_r   <= st_r;
        out_arr_r  <= r_arr_r;
        out_bst_r  <= r_bst_r;
        out_rem_r  <= r_rem_r;
        out_fin_r  <= r_fin_r;
        out_left_r <= count_r;
      end
      default: idx_r <= idx_r;
    endcase
  end

  assign res_valid   = out_valid_r;
  assign res_status  = out_st_r;
  assign res_arrival = FIELD_W'(out_arr_r);
  assign res_burst   = FIELD_W'(out_bst_r);
  assign res_removed = out_rem_r;
  assign res_finish  = out_fin_r;
  assign res_left    = LEFT_W'(out_left_r);

endmodule

// ===== src/job_table_scheduler.sv =====
// Job table scheduler top level: controller plus datapath.
// Depends on jts_pkg, jts_if, jts_ctrl, jts_datapath.
//
// Usage: in_ch carries requests (req_type 0 pushes a task given by
// arrival_time and burst_length, 1 dispatches one scheduling step). Every
// request returns exactly one word on out_ch. cfg_ch writes scheduling_mode
// (index 0) or time_slice (index 1); it is ready out of reset. It is to be
// written only while the block is idle; the block itself does not enforce it.
// Processing: one request is processed at a time. A push reads the table
// from the top down and moves up one slot each entry that sorts at or after
// the new task, then writes the task; a reject or an empty dispatch goes
// straight to the result. FCFS and round robin removal close the gap behind
// the removed task entry by entry; round robin without removal writes back
// the reduced burst. SJF scans the tasks that have arrived by its clock,
// then closes the gap. All steps share the single read port of the table.
// The result sits in an output register: in_ch takes the next request while
// an earlier word waits, and the block holds its next result until out_ch
// is free again.
// Reset empties the table, clears the SJF clock and rotation position, sets
// FCFS mode and a slice of 1. The table memory itself is not cleared.
module job_table_scheduler
  import jts_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  jts_req_if.sink   in_ch,
  jts_res_if.source out_ch,
  jts_cfg_if.sink   cfg_ch
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ch.ready = rst_n;

  jts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_type  (in_ch.req_type),
    .req_ready (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  jts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .req_arrival (in_ch.arrival_time),
    .req_burst   (in_ch.burst_length),
    .cfg_we      (cfg_ch.valid & cfg_ch.ready),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .res_ready   (out_ch.ready),
    .res_valid   (out_ch.valid),
    .res_status  (out_ch.status),
    .res_arrival (out_ch.task_arrival),
    .res_burst   (out_ch.task_burst),
    .res_removed (out_ch.task_removed),
    .res_finish  (out_ch.finish_time),
    .res_left    (out_ch.entries_left)
  );

endmodule

// ===== tb/sv/tb_if.sv =====
// Testbench-side notes: the channel interfaces come from the RTL (jts_if.sv).
// This file holds the shared scheduler model types used by the testbench.
// Depends on jts_pkg.
`timescale 1ns / 100ps
package tb_sched_pkg;
  import jts_pkg::*;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] arrival_time;
    logic [FIELD_W-1:0] burst_length;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] task_arrival;
    logic [FIELD_W-1:0] task_burst;
    logic               task_removed;
    logic [CLOCK_W-1:0] finish_time;
    logic [LEFT_W-1:0]  entries_left;
  } res_word_t;
endpackage

// ===== tb/sv/tb.sv =====
// Testbench top for job_table_scheduler: drives random and directed push and
// dispatch requests, predicts every result word with a behavioral table model.
// Depends on jts_pkg, jts_if and tb_sched_pkg.
`timescale 1ns / 100ps
module tb;
  import jts_pkg::*;
  import tb_sched_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jts_req_if in_ch ();
  jts_res_if out_ch ();
  jts_cfg_if cfg_ch ();

  job_table_scheduler DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // scheduler state mirror
  logic [FIELD_W-1:0] arr_tab [DEPTH];
  logic [FIELD_W-1:0] bur_tab [DEPTH];
  int unsigned        n_tasks;
  logic [CLOCK_W-1:0] run_clock;
  int unsigned        rr_pos;
  logic [MODE_W-1:0]  cur_mode;
  logic [FIELD_W-1:0] cur_slice;

  req_word_t   pending_reqs[$];
  res_word_t   expected_words[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet_in = 0;
  bit          quiet_out = 0;
  bit          hold_send = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void remove_task(int unsigned pos);
    for (int unsigned i = pos; i + 1 < n_tasks; i++) begin
      arr_tab[i] = arr_tab[i+1];
      bur_tab[i] = bur_tab[i+1];
    end
    n_tasks--;
    if (pos < rr_pos) rr_pos--;
    if (rr_pos >= n_tasks) rr_pos = 0;
    if (n_tasks == 0) run_clock = '0;
  endfunction

  function automatic res_word_t schedule_step(req_word_t rq);
    res_word_t r;
    int unsigned pos, best;
    logic [CLOCK_W:0] sum;
    r = '0;
    if (rq.req_type == REQ_PUSH) begin
      if (n_tasks >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < n_tasks && rq.arrival_time > arr_tab[pos]) pos++;
        while (pos < n_tasks && rq.arrival_time == arr_tab[pos] &&
               rq.burst_length > bur_tab[pos]) pos++;
        for (int unsigned i = n_tasks; i > pos; i--) begin
          arr_tab[i] = arr_tab[i-1];
          bur_tab[i] = bur_tab[i-1];
        end
        arr_tab[pos] = rq.arrival_time;
        bur_tab[pos] = rq.burst_length;
        if (n_tasks > 0 && pos <= rr_pos) rr_pos++;
        n_tasks++;
        r.status = ST_PUSH_OK;
      end
    end else if (n_tasks == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status = ST_DISPATCHED;
      if (cur_mode == MODE_SJF) begin
        best = 0;
        if (run_clock < arr_tab[0]) run_clock = arr_tab[0];
        for (int unsigned i = 1; i < n_tasks && arr_tab[i] <= run_clock; i++)
          if (bur_tab[i] < bur_tab[best]) best = i;
        r.task_arrival = arr_tab[best];
        r.task_burst = bur_tab[best];
        sum = run_clock + bur_tab[best];
        run_clock = (sum > CLOCK_MAX) ? CLOCK_MAX : sum[CLOCK_W-1:0];
        r.finish_time = run_clock;
        r.task_removed = 1'b1;
        remove_task(best);
      end else if (cur_mode == MODE_RR) begin
        if (rr_pos >= n_tasks) rr_pos = 0;
        pos = rr_pos;
        r.task_arrival = arr_tab[pos];
        r.task_burst = bur_tab[pos];
        if (bur_tab[pos] <= cur_slice) begin
          r.task_removed = 1'b1;
          remove_task(pos);
        end else begin
          bur_tab[pos] = bur_tab[pos] - cur_slice;
          rr_pos = (pos + 1 >= n_tasks) ? 0 : pos + 1;
        end
      end else begin
        r.task_arrival = arr_tab[0];
        r.task_burst = bur_tab[0];
        r.task_removed = 1'b1;
        remove_task(0);
      end
    end
    r.entries_left = n_tasks[LEFT_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(schedule_step(pending_reqs[0]));
        pending_reqs.delete(0);
      end
      if ((in_ch.valid && !in_ch.ready) ||
          (pending_reqs.size() > 0 && !(in_ch.valid && in_ch.ready)
           && !hold_send && (quiet_in || $urandom_range(99) >= 33))) begin
        if (!in_ch.valid) begin
          in_ch.valid <= 1'b1;
          {in_ch.req_type, in_ch.arrival_time, in_ch.burst_length} <= pending_reqs[0];
        end
      end else if (in_ch.valid && in_ch.ready && pending_reqs.size() > 0 &&
                   !hold_send && (quiet_in || $urandom_range(99) >= 33)) begin
        in_ch.valid <= 1'b1;
        {in_ch.req_type, in_ch.arrival_time, in_ch.burst_length} <= pending_reqs[0];
      end else if (!(in_ch.valid && !in_ch.ready)) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_word_t got, exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_out || ($urandom_range(99) >= 33);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.task_arrival, out_ch.task_burst,
               out_ch.task_removed, out_ch.finish_time, out_ch.entries_left};
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $realtime, got);
        end else begin
          exp_w = expected_words[0];
          expected_words.delete(0);
          if (got.status !== exp_w.status)
            $display("%0t: status exp %0d got %0d", $realtime, exp_w.status, got.status);
          if (got.task_arrival !== exp_w.task_arrival)
            $display("%0t: task_arrival exp %0d got %0d", $realtime,
                     exp_w.task_arrival, got.task_arrival);
          if (got.task_burst !== exp_w.task_burst)
            $display("%0t: task_burst exp %0d got %0d", $realtime,
                     exp_w.task_burst, got.task_burst);
          if (got.task_removed !== exp_w.task_removed)
            $display("%0t: task_removed exp %0d got %0d", $realtime,
                     exp_w.task_removed, got.task_removed);
          if (got.finish_time !== exp_w.finish_time)
            $display("%0t: finish_time exp %0d got %0d", $realtime,
                     exp_w.finish_time, got.finish_time);
          if (got.entries_left !== exp_w.entries_left)
            $display("%0t: entries_left exp %0d got %0d", $realtime,
                     exp_w.entries_left, got.entries_left);
          if (got !== exp_w) errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MODE) cur_mode = val[MODE_W-1:0];
    else cur_slice = val;
  endtask

  task automatic add_req(logic kind, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    pending_reqs.push_back({kind, a, b});
  endtask

  // mostly fill-then-drain bursts with random content; small arrival spans
  // give ties in arrival and burst
  task automatic random_phase(int unsigned n, int unsigned span);
    int unsigned k;
    k = 0;
    while (k < n) begin
      for (int unsigned j = $urandom_range(18); j > 0; j--) begin
        if ($urandom_range(9) == 0)
          add_req(REQ_PUSH, FIELD_W'($urandom), FIELD_W'($urandom));
        else
          add_req(REQ_PUSH, FIELD_W'($urandom_range(span)),
                  FIELD_W'($urandom_range(span)));
        k++;
      end
      for (int unsigned j = $urandom_range(20); j > 0; j--) begin
        add_req($urandom_range(3) != 0, FIELD_W'($urandom_range(span)),
                FIELD_W'($urandom_range(span)));
        k++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_PUSH;
    in_ch.arrival_time = '0;
    in_ch.burst_length = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MODE;
    cfg_ch.data = '0;
    n_tasks = 0;
    run_clock = '0;
    rr_pos = 0;
    cur_mode = MODE_FCFS;
    cur_slice = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dispatch, extremes, overfill, FCFS drain
    add_req(REQ_DISPATCH, 16'hFFFF, 16'hFFFF);
    add_req(REQ_PUSH, 16'hFFFF, 16'hFFFF);
    add_req(REQ_PUSH, 16'h0000, 16'h0000);
    for (int i = 0; i < 15; i++) add_req(REQ_PUSH, 16'h0005, 16'(i * 4099));
    for (int i = 0; i < 17; i++) add_req(REQ_DISPATCH, 16'h0, 16'h0);
    wait_drained();

    // SJF with large arrivals and bursts; the clock stays below its saturation limit
    write_reg(REG_MODE, MODE_SJF);
    for (int i = 0; i < 16; i++) add_req(REQ_PUSH, 16'hFFF0, 16'hFFFF);
    for (int i = 0; i < 17; i++) add_req(REQ_DISPATCH, 16'h0, 16'h0);
    wait_drained();

    // round robin, zero slice then extremes of the slice
    write_reg(REG_MODE, MODE_RR);
    write_reg(REG_SLICE, 16'h0000);
    add_req(REQ_PUSH, 3, 0);
    add_req(REQ_PUSH, 1, 7);
    add_req(REQ_DISPATCH, 0, 0);
    add_req(REQ_DISPATCH, 0, 0);
    add_req(REQ_PUSH, 0, 2);
    add_req(REQ_DISPATCH, 0, 0);
    add_req(REQ_DISPATCH, 0, 0);
    wait_drained();
    write_reg(REG_SLICE, 16'hFFFF);
    add_req(REQ_DISPATCH, 0, 0);
    add_req(REQ_DISPATCH, 0, 0);
    add_req(REQ_DISPATCH, 0, 0);
    wait_drained();

    // random phases over modes and slices, one of them with no idling
    for (int ph = 0; ph < 12; ph++) begin
      quiet_in = (ph == 5);
      quiet_out = (ph == 5);
      write_reg(REG_MODE, MODE_W'(ph % 4));
      write_reg(REG_SLICE, (ph % 3 == 0) ? 16'd1 : 16'($urandom_range(1, 40)));
      random_phase(135, (ph % 2) ? 60 : 65535);
      if (ph == 7) begin
        // hold the sender until the block has answered everything so far
        while (pending_reqs.size() > 75) @(posedge clk);
        hold_send = 1;
        while (in_ch.valid || expected_words.size() > 0) @(posedge clk);
        hold_send = 0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== job_table_scheduler.f =====
src/jts_pkg.sv
src/jts_if.sv
src/jts_ctrl.sv
src/jts_datapath.sv
src/job_table_scheduler.sv
tb/sv/tb_if.sv
tb/sv/tb.sv
